// File: design/unipolar_stepper_phase_sequencer_defines.svh
// Assertion helpers for the stepper sequencer.
`ifndef UNIPOLAR_STEPPER_PHASE_SEQUENCER_DEFINES_SVH
`define UNIPOLAR_STEPPER_PHASE_SEQUENCER_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define USPS_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define USPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/usps_pkg.sv
package usps_pkg;

	// defaults for top-level parameters
	localparam int MAX_STEPS_PER_REV_DEF = 4096;
	localparam int INTERVAL_WIDTH_DEF    = 16;

	// fixed field widths
	localparam int SPR_W      = 13;
	localparam int MODE_W     = 2;
	localparam int INTV_W     = 16;
	localparam int MOVE_W     = 16;
	localparam int PHASES_W   = 17;
	localparam int COILS_W    = 4;
	localparam int POS_OUT_W  = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [MODE_W-1:0] {
		MODE_WAVE = 2'd0,
		MODE_FULL = 2'd1,
		MODE_HALF = 2'd2
	} usps_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPR      = 2'd0,
		CFG_MODE     = 2'd1,
		CFG_INTERVAL = 2'd2
	} usps_cfg_idx_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_MOVE = 1'b1
	} usps_op_t;

	typedef struct packed {
		usps_op_t                  op;
		logic signed [MOVE_W-1:0]  move_count;
	} usps_item_t;

	typedef struct packed {
		logic [SPR_W-1:0]  steps_per_rev;
		logic [MODE_W-1:0] drive_mode;
		logic [INTV_W-1:0] step_interval;
	} usps_cfg_t;

	typedef struct packed {
		logic [COILS_W-1:0]   coils;
		logic                 busy_res;
		logic [POS_OUT_W-1:0] position;
		logic                 move_rejected;
	} usps_result_t;

	// coil pattern tables
	localparam logic [COILS_W-1:0] WAVE_CODES [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
	localparam logic [COILS_W-1:0] FULL_CODES [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
	localparam logic [COILS_W-1:0] HALF_CODES [8] =
		'{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

	// coil pattern for a position; the unused mode code falls back to wave
	function automatic logic [COILS_W-1:0] coil_pattern(input logic [MODE_W-1:0] mode,
		input logic [2:0] idx);
		logic [COILS_W-1:0] code;
		case (mode)
			MODE_HALF: code = HALF_CODES[idx];
			MODE_FULL: code = FULL_CODES[idx[1:0]];
			default:   code = WAVE_CODES[idx[1:0]];
		endcase
		return code;
	endfunction

endpackage

// File: design/unipolar_stepper_phase_sequencer.sv
// Four-coil unipolar stepper sequencer. Each input request is either a
// one-millisecond tick (tuser 0) or a move command (tuser 1, signed step count
// in tdata); every request yields exactly one result with the coil drive,
// busy flag, position and a rejected flag for a move sent while busy. One
// request is taken per clock while the output queue has room: the request is
// registered, the sequencer state is updated from that register, and the
// result lands in a two-entry output queue, so upstream keeps flowing while
// one result waits. Registers are to be written by the user through
// cfg_we/cfg_index/cfg_data only while no request is in flight; the block
// itself does not enforce it. A new value takes effect at once, also during a move.
`include "unipolar_stepper_phase_sequencer_defines.svh"

module unipolar_stepper_phase_sequencer import usps_pkg::*; #(
	parameter int MAX_STEPS_PER_REV = MAX_STEPS_PER_REV_DEF,
	parameter int INTERVAL_WIDTH    = INTERVAL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] move_count
	input  logic                  s_tuser,   // [0] operation
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] coils, [4] busy_res,
	                                         // [16:5] position, [17] move_rejected
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	usps_item_t   item_in;
	usps_item_t   item_s1;
	usps_cfg_t    cfg;
	usps_result_t core_res;
	usps_result_t out_res;
	logic         fire;
	logic         room;

	logic [SPR_W-1:0]  spr_q;
	logic [MODE_W-1:0] mode_q;
	logic [INTV_W-1:0] interval_q;

	// shorthand for the checks at the end
	logic         show_idle;
	logic         show_reject;
	logic         show_drive;
	logic [2:0]   coils_on;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q      <= SPR_W'(2048);
			mode_q     <= MODE_WAVE;
			interval_q <= INTV_W'(29);
		end else if (cfg_we) begin
			case (usps_cfg_idx_t'(cfg_index))
				CFG_SPR:      spr_q      <= cfg_data[SPR_W-1:0];
				CFG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[INTV_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.steps_per_rev = spr_q;
	assign cfg.drive_mode    = mode_q;
	assign cfg.step_interval = interval_q;

	assign item_in.op         = usps_op_t'(s_tuser);
	assign item_in.move_count = s_tdata[MOVE_W-1:0];

	usps_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item_in  (item_in),
		.room     (room),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	usps_core #(
		.MAX_STEPS_PER_REV (MAX_STEPS_PER_REV),
		.INTERVAL_WIDTH    (INTERVAL_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_res)
	);

	usps_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (core_res),
		.room      (room),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_data    (out_res)
	);

	assign m_tdata = {6'b0, out_res.move_rejected, out_res.position, out_res.busy_res,
		out_res.coils};

	assign show_idle   = m_tvalid && !out_res.busy_res;
	assign show_reject = m_tvalid && out_res.move_rejected;
	assign show_drive  = m_tvalid && (out_res.coils != '0);
	assign coils_on    = 3'($countones(out_res.coils));

	// coils are off whenever no move is in progress
	`USPS_ASSERT_IMPL(a_idle_coils_off, show_idle, out_res.coils == '0, "coils driven while idle")
	// a rejected move can only happen during a move
	`USPS_ASSERT_IMPL(a_reject_busy, show_reject, out_res.busy_res, "move rejected while idle")
	// any drive pattern energizes one or two coils
	`USPS_ASSERT_IMPL(a_coil_shape, show_drive, coils_on == 3'd1 || coils_on == 3'd2, "bad coils")
	// the core never commits a request without queue space
	`USPS_ASSERT_IMPL(a_no_overflow, fire, room && u_out.count_q != 2'd3, "result queue overflow")

endmodule

// File: design/usps_in_stage.sv
module usps_in_stage import usps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  usps_item_t item_in,
	input  logic       room,
	output logic       fire,
	output usps_item_t item_s1
);

	logic valid_s1;

	// stage drains whenever the result buffer has room
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: design/usps_core.sv
module usps_core import usps_pkg::*; #(
	parameter int MAX_STEPS_PER_REV = MAX_STEPS_PER_REV_DEF,
	parameter int INTERVAL_WIDTH    = INTERVAL_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  usps_item_t   item,
	input  usps_cfg_t    cfg,
	output usps_result_t result
);

	localparam int POS_W = $clog2(MAX_STEPS_PER_REV);
	localparam int NW    = (POS_W + 1 > SPR_W) ? POS_W + 1 : SPR_W;
	localparam int IW    = INTERVAL_WIDTH;

	// sequencer state
	logic [POS_W-1:0]    pos_q,    pos_n;
	logic [PHASES_W-1:0] phases_q, phases_n;
	logic                rev_q,    rev_n;
	logic [IW-1:0]       ticks_q,  ticks_n;
	logic                first_q,  first_n;
	logic [COILS_W-1:0]  coils_q,  coils_n;
	logic                rejected;

	logic                busy;
	logic                half;
	logic [NW-1:0]       spr_ext;
	logic [NW-1:0]       max_ext;
	logic [NW-1:0]       rev_n_sz;
	logic [NW-1:0]       rev_last;
	logic [NW-1:0]       pos_ext;
	logic [POS_W-1:0]    pos_fwd;
	logic [POS_W-1:0]    pos_bwd;
	logic [POS_W-1:0]    pos_step;
	logic [IW+INTV_W-1:0] intv_wide;
	logic [IW-1:0]       intv_raw;
	logic [IW-1:0]       intv_min;
	logic [IW-1:0]       intv_eff;
	logic [IW-1:0]       ticks_inc;
	logic                neg;
	logic [MOVE_W:0]     neg_mag;
	logic [MOVE_W-1:0]   mag;
	logic [PHASES_W-1:0] phases_load;
	logic [PHASES_W-1:0] phases_dec;
	logic                do_step;
	logic [POS_W+POS_OUT_W-1:0] pos_wide;

	assign busy = (phases_q != '0);
	assign half = (cfg.drive_mode == MODE_HALF);

	// effective revolution size, clamped to 1..MAX_STEPS_PER_REV
	assign spr_ext  = NW'(cfg.steps_per_rev);
	assign max_ext  = NW'(MAX_STEPS_PER_REV);
	assign rev_n_sz = (spr_ext == '0) ? NW'(1) : ((spr_ext > max_ext) ? max_ext : spr_ext);
	assign rev_last = rev_n_sz - NW'(1);
	assign pos_ext  = NW'(pos_q);

	// next position in each direction; out-of-range position snaps to an end
	assign pos_fwd  = (pos_ext + NW'(1) >= rev_n_sz) ? '0 : pos_q + POS_W'(1);
	assign pos_bwd  = (pos_q == '0 || pos_ext >= rev_n_sz) ? rev_last[POS_W-1:0]
		: pos_q - POS_W'(1);
	assign pos_step = rev_q ? pos_bwd : pos_fwd;

	// interval clamped to the mode minimum
	assign intv_wide = {{IW{1'b0}}, cfg.step_interval};
	assign intv_raw  = intv_wide[IW-1:0];
	assign intv_min  = half ? IW'(3) : IW'(2);
	assign intv_eff  = (intv_raw < intv_min) ? intv_min : intv_raw;
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + IW'(1);

	// move magnitude and phase count
	assign neg         = item.move_count[MOVE_W-1];
	assign neg_mag     = (MOVE_W+1)'(1 << MOVE_W) - {1'b0, item.move_count};
	assign mag         = neg ? neg_mag[MOVE_W-1:0] : item.move_count;
	assign phases_load = half ? {mag, 1'b0} : PHASES_W'(mag);
	assign phases_dec  = phases_q - PHASES_W'(1);

	assign do_step = first_q || (ticks_inc >= intv_eff);

	// next-state logic for one request
	always_comb begin
		pos_n    = pos_q;
		phases_n = phases_q;
		rev_n    = rev_q;
		ticks_n  = ticks_q;
		first_n  = first_q;
		coils_n  = coils_q;
		rejected = 1'b0;
		if (item.op == OP_MOVE) begin
			if (busy) begin
				rejected = 1'b1;
			end else begin
				phases_n = phases_load;
				rev_n    = neg;
				ticks_n  = '0;
				first_n  = (phases_load != '0);
			end
		end else if (busy) begin
			if (!first_q) begin
				ticks_n = ticks_inc;
			end
			if (do_step) begin
				pos_n    = pos_step;
				phases_n = phases_dec;
				ticks_n  = '0;
				first_n  = 1'b0;
				coils_n  = (phases_dec == '0) ? '0 : coil_pattern(cfg.drive_mode, pos_step[2:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phases_q <= '0;
			rev_q    <= 1'b0;
			ticks_q  <= '0;
			first_q  <= 1'b0;
			coils_q  <= '0;
		end else if (fire) begin
			pos_q    <= pos_n;
			phases_q <= phases_n;
			rev_q    <= rev_n;
			ticks_q  <= ticks_n;
			first_q  <= first_n;
			coils_q  <= coils_n;
		end
	end

	// result reflects the state after this request
	assign pos_wide             = {{POS_OUT_W{1'b0}}, pos_n};
	assign result.coils         = coils_n;
	assign result.busy_res      = (phases_n != '0);
	assign result.position      = pos_wide[POS_OUT_W-1:0];
	assign result.move_rejected = rejected;

endmodule

// File: design/usps_out_buf.sv
module usps_out_buf import usps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  usps_result_t push_data,
	output logic         room,
	output logic         m_tvalid,
	input  logic         m_tready,
	output usps_result_t m_data
);

	// two-entry result queue; room depends on registers only
	usps_result_t entry_q [2];
	logic [1:0]   count_q;
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic         pop;

	assign room     = !count_q[1];
	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign m_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sim/tb_unipolar_stepper_phase_sequencer.sv
module tb_unipolar_stepper_phase_sequencer;
	import usps_pkg::*;

	localparam int RANDOM_ITEMS = 1100;
	localparam int HOLD_CYCLES = 200;
	localparam int RUN_LIMIT = 10_000_000;
	localparam int MAX_MISMATCH_LINES = 40;
	// mode code with no table of its own; the block treats it as wave drive
	localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

	localparam logic [COILS_W-1:0] ONE_COIL [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
	localparam logic [COILS_W-1:0] TWO_COIL [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
	localparam logic [COILS_W-1:0] HALF_SEQ [8] =
		'{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

	typedef struct packed {
		logic [COILS_W-1:0]   coils;
		logic                 busy;
		logic [POS_OUT_W-1:0] position;
		logic                 rejected;
	} coil_report_t;

	// Tracks the sequencer state and holds the coil reports still owed by the block.
	class coil_sequence_tracker;
		logic [SPR_W-1:0]  rev_reg;
		logic [MODE_W-1:0] mode;
		logic [INTV_W-1:0] interval_reg;
		int unsigned       position;
		int unsigned       phases_left;
		int unsigned       ticks;
		bit                reverse;
		bit                first_pending;
		logic [COILS_W-1:0] coils;
		coil_report_t      expected_reports[$];
		int                errors;

		function new();
			rev_reg = 13'd2048;
			mode = MODE_WAVE;
			interval_reg = 16'd29;
			position = 0;
			phases_left = 0;
			ticks = 0;
			reverse = 1'b0;
			first_pending = 1'b0;
			coils = '0;
			errors = 0;
		endfunction

		function void write_reg(usps_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_SPR:      rev_reg = value[SPR_W-1:0];
				CFG_MODE:     mode = value[MODE_W-1:0];
				CFG_INTERVAL: interval_reg = value[INTV_W-1:0];
				default:      ;
			endcase
		endfunction

		function int unsigned rev_size();
			int unsigned n;
			n = rev_reg;
			if (n == 0) n = 1;
			if (n > MAX_STEPS_PER_REV_DEF) n = MAX_STEPS_PER_REV_DEF;
			return n;
		endfunction

		function int unsigned eff_interval();
			int unsigned floor_val;
			floor_val = (mode == MODE_HALF) ? 3 : 2;
			return (interval_reg < floor_val) ? floor_val : interval_reg;
		endfunction

		function logic [COILS_W-1:0] coil_code();
			if (mode == MODE_HALF) return HALF_SEQ[position[2:0]];
			if (mode == MODE_FULL) return TWO_COIL[position[1:0]];
			return ONE_COIL[position[1:0]];
		endfunction

		// one phase change; a position past a shrunken revolution snaps to an end
		function void phase_change();
			int unsigned n;
			n = rev_size();
			if (!reverse)
				position = (position + 1 >= n) ? 0 : position + 1;
			else
				position = (position == 0 || position >= n) ? n - 1 : position - 1;
			phases_left--;
			ticks = 0;
			first_pending = 1'b0;
			coils = (phases_left == 0) ? '0 : coil_code();
		endfunction

		function void note_request(usps_op_t op, logic [IN_DATA_W-1:0] data);
			coil_report_t rep;
			int unsigned mag;
			bit neg;
			bit rejected;
			rejected = 1'b0;
			if (op == OP_MOVE) begin
				if (phases_left != 0) begin
					rejected = 1'b1;
				end else begin
					neg = data[15];
					mag = neg ? (32'h10000 - data) : data;
					phases_left = mag * ((mode == MODE_HALF) ? 2 : 1);
					reverse = neg;
					ticks = 0;
					first_pending = (phases_left != 0);
				end
			end else if (phases_left != 0) begin
				if (first_pending) begin
					phase_change();
				end else begin
					if (ticks < 65535) ticks++;
					if (ticks >= eff_interval()) phase_change();
				end
			end
			rep.coils = coils;
			rep.busy = (phases_left != 0);
			rep.position = position[POS_OUT_W-1:0];
			rep.rejected = rejected;
			expected_reports.push_back(rep);
		endfunction

		function void mismatch(string field, logic [15:0] want, logic [15:0] got);
			if (errors < MAX_MISMATCH_LINES)
				$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] word);
			coil_report_t want;
			coil_report_t got;
			got.coils = word[3:0];
			got.busy = word[4];
			got.position = word[16:5];
			got.rejected = word[17];
			if (expected_reports.size() == 0) begin
				if (errors < MAX_MISMATCH_LINES)
					$display("%0t: result %h with none expected, expected none", $time, word);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.coils !== want.coils) mismatch("coils", want.coils, got.coils);
			if (got.busy !== want.busy) mismatch("busy_res", want.busy, got.busy);
			if (got.position !== want.position)
				mismatch("position", want.position, got.position);
			if (got.rejected !== want.rejected)
				mismatch("move_rejected", want.rejected, got.rejected);
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit          source_steady = 1'b0;
	bit          sink_steady = 1'b0;
	bit          hold_results = 1'b0;
	int unsigned item_count = 0;

	coil_sequence_tracker tracker = new();

	unipolar_stepper_phase_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned magnitude(logic signed [MOVE_W-1:0] c);
		return (c < 0) ? -int'(c) : int'(c);
	endfunction

	// register writes, accepted requests and results, all sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) tracker.write_reg(usps_cfg_idx_t'(cfg_index), cfg_data);
			if (s_tvalid && s_tready) tracker.note_request(usps_op_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) tracker.check_result(m_tdata);
		end
	end

	// result side: random ready with gaps, plus long hold-offs on request
	initial begin : result_sink
		int run;
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else begin
				run = $urandom_range(1, 12);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
				gap = sink_steady ? 0 : idle_len();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	task automatic send_item(input usps_op_t op, input logic [IN_DATA_W-1:0] data);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (s_tready !== 1'b1);
		item_count++;
		gap = source_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(OP_TICK, 16'($urandom));
	endtask

	// stop sending and let every owed result drain out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input usps_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic shuffle_config();
		bit [2:0] pick;
		int r;
		logic [CFG_DATA_W-1:0] v;
		pick = 3'($urandom_range(1, 7));
		if (pick[0]) begin
			r = $urandom_range(0, 9);
			case (r)
				0: v = 16'd0;
				1: v = 16'd1;
				2: v = 16'(MAX_STEPS_PER_REV_DEF);
				3: v = {3'b000, {SPR_W{1'b1}}};
				4, 5: v = 16'($urandom_range(2, 16));
				default: v = 16'($urandom_range(1, MAX_STEPS_PER_REV_DEF));
			endcase
			v[CFG_DATA_W-1:SPR_W] = 3'($urandom);
			write_register(CFG_SPR, v);
		end
		if (pick[1]) begin
			v = 16'($urandom);
			write_register(CFG_MODE, v);
		end
		if (pick[2]) begin
			r = $urandom_range(0, 99);
			if (r < 10) v = 16'($urandom_range(0, 1));
			else if (r < 85) v = 16'($urandom_range(2, 6));
			else if (r < 95) v = 16'($urandom_range(7, 12));
			else v = 16'($urandom_range(20, 40));
			write_register(CFG_INTERVAL, v);
		end
	endtask

	// a move from idle followed by enough ticks to finish it; noise moves
	// only go in while the move is still running so they are always rejected
	task automatic run_move(input logic signed [MOVE_W-1:0] cnt, input bit noisy);
		int unsigned phases;
		int unsigned need;
		int unsigned total;
		int unsigned j;
		send_item(OP_MOVE, cnt);
		phases = magnitude(cnt) * ((tracker.mode == MODE_HALF) ? 2 : 1);
		need = (phases == 0) ? 0 : 1 + (phases - 1) * tracker.eff_interval();
		total = need + $urandom_range(0, 3);
		for (j = 1; j <= total; j++) begin
			if (noisy && j <= need && $urandom_range(0, 19) == 0)
				send_item(OP_MOVE, 16'($urandom));
			send_item(OP_TICK, 16'($urandom));
		end
	endtask

	// move with a register change part way through; ticks after the change
	// are an upper bound on what the rest of the move can take
	task automatic run_move_retuned(input logic signed [MOVE_W-1:0] cnt);
		int unsigned phases;
		int unsigned need;
		send_item(OP_MOVE, cnt);
		phases = magnitude(cnt) * ((tracker.mode == MODE_HALF) ? 2 : 1);
		need = (phases == 0) ? 0 : 1 + (phases - 1) * tracker.eff_interval();
		if (need < 2) begin
			send_ticks(need);
		end else begin
			send_ticks($urandom_range(1, need - 1));
			case ($urandom_range(0, 2))
				0: write_register(CFG_INTERVAL, 16'($urandom_range(0, 8)));
				1: write_register(CFG_MODE, 16'($urandom_range(0, 3)));
				default: write_register(CFG_SPR, 16'($urandom_range(0, 64)));
			endcase
			send_ticks(phases * tracker.eff_interval() + 1);
		end
	endtask

	initial begin : stimulus
		int unsigned start_count;
		int unsigned mag;
		int r;
		logic signed [MOVE_W-1:0] cnt;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, zero move, single steps both ways, moves while busy
		send_item(OP_TICK, 16'hFFFF);
		send_item(OP_MOVE, 16'h0000);
		write_register(CFG_INTERVAL, 16'd1);
		run_move(16'sd1, 1'b0);
		run_move(-16'sd1, 1'b0);
		send_item(OP_MOVE, 16'd3);
		send_item(OP_MOVE, 16'h7FFF);
		send_item(OP_MOVE, 16'h8000);
		send_item(OP_MOVE, 16'hFFFF);
		send_ticks(5);

		// longest interval, then shorten it and switch mode mid move
		write_register(CFG_MODE, MODE_HALF);
		write_register(CFG_INTERVAL, 16'hFFFF);
		send_item(OP_MOVE, 16'd3);
		send_ticks(8);
		write_register(CFG_INTERVAL, 16'd0);
		send_ticks(1);
		write_register(CFG_MODE, MODE_FULL);
		send_ticks(4 * 2 + 2);

		// revolution size extremes and positions past a shrunken revolution
		write_register(CFG_MODE, MODE_WAVE);
		write_register(CFG_INTERVAL, 16'd2);
		write_register(CFG_SPR, 16'(MAX_STEPS_PER_REV_DEF));
		run_move(-16'sd5, 1'b1);
		write_register(CFG_SPR, {3'b000, {SPR_W{1'b1}}});
		run_move(16'sd3, 1'b0);
		write_register(CFG_SPR, 16'd10);
		run_move(16'sd2, 1'b0);
		run_move(-16'sd2, 1'b0);
		write_register(CFG_SPR, 16'(MAX_STEPS_PER_REV_DEF));
		run_move(-16'sd3, 1'b0);
		write_register(CFG_SPR, 16'd5);
		run_move(-16'sd1, 1'b0);
		write_register(CFG_SPR, 16'd0);
		run_move(16'sd3, 1'b0);
		write_register(CFG_MODE, {14'd0, MODE_UNDEF});
		write_register(CFG_SPR, 16'd2048);
		run_move(16'sd6, 1'b0);

		// result side stalls long while requests keep coming
		hold_results = 1'b1;
		source_steady = 1'b1;
		run_move(16'sd12, 1'b1);
		source_steady = 1'b0;
		wait_idle();

		// random moves with random settings
		start_count = item_count;
		while (item_count - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) shuffle_config();
			source_steady = ($urandom_range(0, 4) == 0);
			sink_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 11) == 0) begin
				hold_results = 1'b1;
				source_steady = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 8) mag = 0;
			else if (r < 85) mag = $urandom_range(1, 8);
			else mag = $urandom_range(9, 24);
			if (tracker.eff_interval() > 8 && mag > 3) mag = 3;
			cnt = MOVE_W'(mag);
			if ($urandom_range(0, 1)) cnt = -cnt;
			if ($urandom_range(0, 12) == 0) run_move_retuned(cnt);
			else run_move(cnt, 1'b1);
			if ($urandom_range(0, 15) == 0) wait_idle();
		end
		source_steady = 1'b0;
		sink_steady = 1'b0;

		// most negative count in half step: the phase count fills all 17 bits,
		// so the move is only started and a few phase changes are checked
		write_register(CFG_MODE, MODE_HALF);
		write_register(CFG_INTERVAL, 16'd1);
		write_register(CFG_SPR, 16'($urandom_range(1, MAX_STEPS_PER_REV_DEF)));
		source_steady = 1'b1;
		sink_steady = 1'b1;
		send_item(OP_MOVE, 16'h8000);
		send_ticks(20);
		send_item(OP_MOVE, 16'h8000);
		send_ticks(20);
		source_steady = 1'b0;
		sink_steady = 1'b0;

		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("** unipolar_stepper_phase_sequencer: PASSED **");
		else
			$display("** unipolar_stepper_phase_sequencer: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#RUN_LIMIT;
		$display("** unipolar_stepper_phase_sequencer: FAILED **");
		$finish;
	end

endmodule
